[rtl/qte_pkg.sv]
// shared types, constants and helper functions of the quaternion to euler angle block
package qte_pkg;

    // number of vectoring iterations per angle lane (8 to 24)
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    // square root cells: one result bit each, radicand up to 2^56
    localparam int SQRT_STEPS   = 29;
    localparam int SQRT_TOP     = 56;

    // widths
    localparam int PW  = 34;    // atan2 operands, 28 fraction bits
    localparam int XW  = 36;    // cordic x and y with gain headroom
    localparam int ZW  = 32;    // cordic angle, 28 fraction bits
    localparam int RW  = 58;    // square root remainder and result
    localparam int IW  = 5;     // cell index

    localparam logic signed [PW-1:0] ONE_Q28     = PW'(64'sd268435456);
    localparam logic signed [ZW-1:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [15:0]   PI_Q12      = 16'sd12868;
    localparam logic signed [15:0]   HALF_PI_Q12 = 16'sd6434;

    localparam logic signed [ZW-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    // atan2 operands carried alongside the square root
    typedef struct packed {
        logic signed [PW-1:0] sr;
        logic signed [PW-1:0] cr;
        logic signed [PW-1:0] sy;
        logic signed [PW-1:0] cy;
        logic signed [PW-1:0] sp;
        logic                 sat;
    } side_t;

    typedef struct packed {
        logic          valid;
        logic [RW-1:0] rem;
        logic [RW-1:0] res;
        side_t         side;
    } sq_t;

    typedef struct packed {
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        logic  valid;
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
        logic  sat;
        logic  neg;
    } cd_t;

    // fold a left half-plane vector into the right half-plane
    function automatic lane_t lane_prep(logic signed [PW-1:0] y, logic signed [PW-1:0] x);
        lane_t l;
        l.zero = (x == '0) && (y == '0);
        l.x    = XW'(x);
        l.y    = XW'(y);
        l.z    = '0;
        if (x < 0)
        begin
            l.z = (y >= 0) ? PI_Q28 : -PI_Q28;
            l.x = -l.x;
            l.y = -l.y;
        end
        return l;
    endfunction

    // one vectoring rotation
    function automatic lane_t lane_rot(lane_t l, logic [IW-1:0] i);
        lane_t                r;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        r  = l;
        dx = l.y >>> i;
        dy = l.x >>> i;
        if (l.y >= 0)
        begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + ATAN_TAB[i];
        end
        else
        begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - ATAN_TAB[i];
        end
        return r;
    endfunction

    // round to 12 fraction bits, halves away from zero, then clamp; a zero vector gives zero
    function automatic logic signed [15:0] round_angle(lane_t l, logic signed [15:0] lim);
        logic signed [ZW:0] ze;
        logic signed [ZW:0] q;
        logic signed [ZW:0] le;
        ze = (ZW+1)'(l.z);
        le = (ZW+1)'(lim);
        if (ze >= 0)
            q = (ze + 33'sd32768) >>> 16;
        else
            q = -((-ze + 33'sd32768) >>> 16);
        if (q > le)
            q = le;
        if (q < -le)
            q = -le;
        if (l.zero)
            q = '0;
        return q[15:0];
    endfunction

endpackage

[rtl/quaternion_to_euler_angles_top.sv]
// top level: quaternion in, roll, pitch and yaw out through a cell pipeline
// Takes one quaternion per cycle unless stalled, returns one set of angles each, in order.
// Its stages are four front stages for products and sums, 29 square root cells for the pitch
// cosine, one fold stage, one cordic cell per iteration shared by the three angle lanes,
// and the rounding output register. A stall on the output stops the chain only when its
// last cell holds a transaction; bubbles ahead of it still drain.
module quaternion_to_euler_angles_top
    import qte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic [0:0]  m_tuser    // pitch_saturated
);

    logic en;
    sq_t  sq_chain [0:SQRT_STEPS];
    cd_t  cd_chain [0:CORDIC_STEPS];
    cd_t  prep_reg;
    logic               m_tvalid_reg;
    logic signed [14:0] roll_reg;
    logic signed [13:0] pitch_reg;
    logic signed [14:0] yaw_reg;
    logic               sat_reg;
    logic signed [15:0] pitch_full;

    // chain advances unless a finished transaction is blocked at the output
    assign en       = m_tready || !m_tvalid_reg || !cd_chain[CORDIC_STEPS].valid;
    assign s_tready = en;

    qte_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .quat_w   (s_tdata[15:0]),
        .quat_x   (s_tdata[31:16]),
        .quat_y   (s_tdata[47:32]),
        .quat_z   (s_tdata[63:48]),
        .sq_out   (sq_chain[0])
    );

    // square root chain
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        qte_sqrt_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .idx      (IW'(k)),
            .cell_in  (sq_chain[k]),
            .cell_out (sq_chain[k+1])
        );
    end

    // fold stage into the right half-plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_reg <= '0;
        else if (en)
        begin
            prep_reg.valid <= sq_chain[SQRT_STEPS].valid;
            prep_reg.roll  <= lane_prep(sq_chain[SQRT_STEPS].side.sr,
                                        sq_chain[SQRT_STEPS].side.cr);
            prep_reg.yaw   <= lane_prep(sq_chain[SQRT_STEPS].side.sy,
                                        sq_chain[SQRT_STEPS].side.cy);
            prep_reg.pitch <= lane_prep(sq_chain[SQRT_STEPS].side.sp,
                                        PW'(sq_chain[SQRT_STEPS].res));
            prep_reg.sat   <= sq_chain[SQRT_STEPS].side.sat;
            prep_reg.neg   <= sq_chain[SQRT_STEPS].side.sp < 0;
        end
    end

    assign cd_chain[0] = prep_reg;

    // cordic chain
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        qte_cordic_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .idx      (IW'(k)),
            .cell_in  (cd_chain[k]),
            .cell_out (cd_chain[k+1])
        );
    end

    // pitch select between saturation and cordic result
    always_comb
    begin
        if (cd_chain[CORDIC_STEPS].sat)
            pitch_full = cd_chain[CORDIC_STEPS].neg ? -HALF_PI_Q12 : HALF_PI_Q12;
        else
            pitch_full = round_angle(cd_chain[CORDIC_STEPS].pitch, HALF_PI_Q12);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (m_tready || !m_tvalid_reg)
            m_tvalid_reg <= cd_chain[CORDIC_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !m_tvalid_reg)
        begin
            roll_reg  <= 15'(round_angle(cd_chain[CORDIC_STEPS].roll, PI_Q12));
            yaw_reg   <= 15'(round_angle(cd_chain[CORDIC_STEPS].yaw, PI_Q12));
            pitch_reg <= pitch_full[13:0];
            sat_reg   <= cd_chain[CORDIC_STEPS].sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, yaw_reg, pitch_reg, roll_reg};
    assign m_tuser  = sat_reg;

endmodule

[rtl/qte_front.sv]
// product, sum and radicand stages ahead of the square root chain
module qte_front
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output sq_t                sq_out
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [31:0] xy_reg, zz_reg, wy_reg, zx_reg;
    side_t              side2_reg, side3_reg, side_next;
    logic [28:0]        mag_reg, mag_next;
    logic [RW-1:0]      magsq_reg;
    sq_t                out_reg;

    // operand sums
    always_comb
    begin
        logic signed [PW-1:0] mag;
        side_next.sr  = (PW'(wx_reg) + PW'(yz_reg)) <<< 1;
        side_next.cr  = ONE_Q28 - ((PW'(xx_reg) + PW'(yy_reg)) <<< 1);
        side_next.sy  = (PW'(wz_reg) + PW'(xy_reg)) <<< 1;
        side_next.cy  = ONE_Q28 - ((PW'(yy_reg) + PW'(zz_reg)) <<< 1);
        side_next.sp  = (PW'(wy_reg) - PW'(zx_reg)) <<< 1;
        side_next.sat = (side_next.sp >= ONE_Q28) || (side_next.sp <= -ONE_Q28);
        mag           = (side_next.sp < 0) ? -side_next.sp : side_next.sp;
        mag_next      = mag[28:0];
    end

    // valid bits and the radicand output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            out_reg <= '0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_reg.valid <= v3_reg;
            out_reg.side  <= side3_reg;
            out_reg.rem   <= (RW'(1) << SQRT_TOP) - magsq_reg;
            out_reg.res   <= '0;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg    <= quat_w * quat_x;
            yz_reg    <= quat_y * quat_z;
            xx_reg    <= quat_x * quat_x;
            yy_reg    <= quat_y * quat_y;
            wz_reg    <= quat_w * quat_z;
            xy_reg    <= quat_x * quat_y;
            zz_reg    <= quat_z * quat_z;
            wy_reg    <= quat_w * quat_y;
            zx_reg    <= quat_z * quat_x;
            side2_reg <= side_next;
            mag_reg   <= mag_next;
            side3_reg <= side2_reg;
            magsq_reg <= RW'(mag_reg * mag_reg);
        end
    end

    assign sq_out = out_reg;

endmodule

[rtl/qte_sqrt_cell.sv]
// one bit of the restoring integer square root
module qte_sqrt_cell
    import qte_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [IW-1:0] idx,
    input  sq_t           cell_in,
    output sq_t           cell_out
);

    sq_t           cell_reg, cell_next;
    logic [RW-1:0] bit_val;
    logic [5:0]    amt;

    // trial subtract of the current bit
    always_comb
    begin
        amt       = 6'(SQRT_TOP) - {idx, 1'b0};
        bit_val   = RW'(1) << amt;
        cell_next = cell_in;
        if (cell_in.rem >= cell_in.res + bit_val)
        begin
            cell_next.rem = cell_in.rem - (cell_in.res + bit_val);
            cell_next.res = (cell_in.res >> 1) + bit_val;
        end
        else
            cell_next.res = cell_in.res >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (en)
            cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

[rtl/qte_cordic_cell.sv]
// one vectoring iteration for the roll, pitch and yaw lanes
module qte_cordic_cell
    import qte_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [IW-1:0] idx,
    input  cd_t           cell_in,
    output cd_t           cell_out
);

    cd_t cell_reg;

    // rotate each lane toward the x axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (en)
        begin
            cell_reg.valid <= cell_in.valid;
            cell_reg.roll  <= lane_rot(cell_in.roll, idx);
            cell_reg.pitch <= lane_rot(cell_in.pitch, idx);
            cell_reg.yaw   <= lane_rot(cell_in.yaw, idx);
            cell_reg.sat   <= cell_in.sat;
            cell_reg.neg   <= cell_in.neg;
        end
    end

    assign cell_out = cell_reg;

endmodule
